// ===== hw/rtl/dqf_pkg.sv =====
// ----------------------------------------------------------------------------
// dqf_pkg
// Shared types and constants for the decimal quotient formatter.
// ----------------------------------------------------------------------------
package dqf_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 32;
    localparam int FRAC_W     = 6;
    localparam int SYM_W      = 4;

    typedef logic [SYM_W-1:0] t_digit;

    // symbol codes
    localparam t_digit SYM_POINT = 4'd10;
    localparam t_digit DIG_ZERO  = 4'd0;
    localparam t_digit DIG_ONE   = 4'd1;
    localparam t_digit DIG_HALF  = 4'd5;
    localparam t_digit DIG_NINE  = 4'd9;

    // shared add/subtract unit operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic clr;     // zero the BCD register
        logic dabble;  // adjust digits and shift one binary bit in
        logic rot;     // rotate left by one digit
        logic bit_in;  // binary bit entering on dabble
    } t_bcd_ctl;

endpackage

// ===== hw/rtl/dqf_in_if.sv =====
// ----------------------------------------------------------------------------
// dqf_in_if
// Request channel: dividend, divisor and decimal places with valid/ready.
// ----------------------------------------------------------------------------
interface dqf_in_if import dqf_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic [FRAC_W-1:0]     frac_places;

    modport source (output valid, output dividend, output divisor, output frac_places,
                    input ready);
    modport sink   (input valid, input dividend, input divisor, input frac_places,
                    output ready);

endinterface

// ===== hw/rtl/dqf_out_if.sv =====
// ----------------------------------------------------------------------------
// dqf_out_if
// Symbol channel: one decimal symbol per transfer with error and last flags.
// ----------------------------------------------------------------------------
interface dqf_out_if import dqf_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             div_error;
    logic             last;

    modport source (output valid, output symbol, output div_error, output last,
                    input ready);
    modport sink   (input valid, input symbol, input div_error, input last,
                    output ready);

endinterface

// ===== hw/rtl/dqf_ram.sv =====
// ----------------------------------------------------------------------------
// dqf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dqf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 51
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/dqf_alu.sv =====
// ----------------------------------------------------------------------------
// dqf_alu
// Shared add/subtract unit; carry out high on subtract means no borrow.
// ----------------------------------------------------------------------------
module dqf_alu import dqf_pkg::*; #(
    parameter int WIDTH = 36
) (
    input  logic             i_op,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_res,
    output logic             o_carry
);

    logic [WIDTH-1:0] b_eff;
    logic [WIDTH:0]   sum;

    assign b_eff = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign sum   = {1'b0, i_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, (i_op == ALU_SUB)};
    assign o_res   = sum[WIDTH-1:0];
    assign o_carry = sum[WIDTH];

endmodule

// ===== hw/rtl/dqf_bcd.sv =====
// ----------------------------------------------------------------------------
// dqf_bcd
// BCD register: shift-and-add-3 conversion of the integer quotient, then
// digit rotation so the sequencer reads the top digit each cycle.
// ----------------------------------------------------------------------------
module dqf_bcd import dqf_pkg::*; #(
    parameter int NUM_DIG = 10
) (
    input  logic     i_clk,
    input  t_bcd_ctl i_ctl,
    output t_digit   o_top
);

    localparam int BW = NUM_DIG * SYM_W;

    logic [BW-1:0] r_bcd;
    logic [BW-1:0] n_bcd;
    logic [BW-1:0] adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIG; d++) begin
            adj[d*SYM_W +: SYM_W] = (r_bcd[d*SYM_W +: SYM_W] >= DIG_HALF)
                                  ? r_bcd[d*SYM_W +: SYM_W] + 4'd3
                                  : r_bcd[d*SYM_W +: SYM_W];
        end
    end

    always_comb begin
        n_bcd = r_bcd;
        if (i_ctl.clr) begin
            n_bcd = '0;
        end else if (i_ctl.dabble) begin
            n_bcd = {adj[BW-2:0], i_ctl.bit_in};
        end else if (i_ctl.rot) begin
            n_bcd = {r_bcd[BW-SYM_W-1:0], r_bcd[BW-1 -: SYM_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd <= n_bcd;
    end

    assign o_top = r_bcd[BW-1 -: SYM_W];

endmodule

// ===== hw/rtl/decimal_quotient_formatter_core.sv =====
// ----------------------------------------------------------------------------
// decimal_quotient_formatter_core
// Rounded decimal quotient of two unsigned numbers, one symbol per transfer.
//
//   Channel  Dir  Handshake     Payload
//   i_in     in   valid/ready   dividend, divisor, frac_places
//   o_out    out  valid/ready   symbol (0-9 digit, 10 point), div_error, last
//
// Steps: binary division, BCD conversion of the integer quotient, then P+1 fraction
// digits, with P the saturated place count and the extra digit for rounding; then the
// D integer digit slots (10 at 32 bits) are walked once to find the rounding target
// and once to emit. A zero divisor goes straight to the error symbol. One add/subtract
// unit carries the binary division (one bit a cycle) and each fraction digit (one
// multiply by ten, four compare steps). A shown symbol that waits for o_out.ready stalls.
// Reset (synchronous, active low) idles the sequencer and empties the output.
// i_in.ready is high only while idle; the output register lets the next item
// start while the final symbol of the previous one waits for o_out.ready.
// ----------------------------------------------------------------------------
module decimal_quotient_formatter_core import dqf_pkg::*; #(
    parameter int MAX_FRAC   = 50,
    parameter int DATA_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dqf_in_if.sink    i_in,
    dqf_out_if.source o_out
);

    localparam int W          = DATA_WIDTH;
    localparam int UW         = DATA_WIDTH + 4;
    localparam int INT_DIGITS = (DATA_WIDTH * 302) / 1000 + 1;
    localparam int IDX_W      = $clog2(INT_DIGITS);
    localparam int CNT_MAX    = (DATA_WIDTH > MAX_FRAC) ? DATA_WIDTH : MAX_FRAC;
    localparam int CNT_W      = $clog2(CNT_MAX + 2);
    localparam int RAM_DEPTH  = MAX_FRAC + 1;
    localparam int FRAC_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV   = 4'd1;
    localparam logic [3:0] ST_BCD   = 4'd2;
    localparam logic [3:0] ST_FRAC  = 4'd3;
    localparam logic [3:0] ST_SCAN  = 4'd4;
    localparam logic [3:0] ST_EINT  = 4'd5;
    localparam logic [3:0] ST_EPT   = 4'd6;
    localparam logic [3:0] ST_EFRAC = 4'd7;
    localparam logic [3:0] ST_ERR   = 4'd8;

    localparam logic [2:0] SUB_MUL  = 3'd0;
    localparam logic [2:0] SUB_LAST = 3'd4;

    // control state
    logic [3:0]       r_state, n_state;
    logic             r_out_valid, n_out_valid;
    // datapath state
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [2:0]       r_sub, n_sub;
    logic [UW-1:0]    r_acc, n_acc;
    logic [W-1:0]     r_q, n_q;
    logic [W-1:0]     r_den, n_den;
    logic [CNT_W-1:0] r_places, n_places;
    logic [2:0]       r_dig, n_dig;
    logic             r_round, n_round;
    logic             r_fnn_valid, n_fnn_valid;
    logic [FRAC_AW-1:0] r_fnn, n_fnn;
    logic [IDX_W-1:0] r_inn, n_inn;
    logic             r_seen, n_seen;
    t_digit           r_sym, n_sym;
    logic             r_err, n_err;
    logic             r_last, n_last;

    logic             alu_op;
    logic [UW-1:0]    alu_a, alu_b, alu_res;
    logic             alu_carry;
    t_bcd_ctl         bcd_ctl;
    t_digit           bcd_top;
    logic             ram_we, ram_re;
    logic [FRAC_AW-1:0] ram_waddr, ram_raddr;
    t_digit           ram_wdata, ram_rdata;

    logic [W-1:0]     in_dividend, in_divisor;
    logic [CNT_W-1:0] in_places;
    logic [CNT_W-1:0] cnt_inc;
    logic             out_free;
    t_digit           dig_final;
    t_digit           int_dv, frac_dv;
    logic             int_hit, int_show;

    assign in_dividend = i_in.dividend[W-1:0];
    assign in_divisor  = i_in.divisor[W-1:0];
    assign in_places   = (i_in.frac_places > FRAC_W'(MAX_FRAC))
                       ? CNT_W'(MAX_FRAC) : CNT_W'(i_in.frac_places);
    assign cnt_inc     = r_cnt + 1'b1;
    assign out_free    = !r_out_valid || o_out.ready;
    assign dig_final   = {r_dig, alu_carry};

    // rounding: the last non-nine digit takes the carry, the nines after it go to zero
    assign int_hit = r_round && !r_fnn_valid;
    always_comb begin
        if (int_hit && (r_cnt == CNT_W'(r_inn))) begin
            int_dv = bcd_top + DIG_ONE;
        end else if (int_hit && (r_cnt > CNT_W'(r_inn))) begin
            int_dv = DIG_ZERO;
        end else begin
            int_dv = bcd_top;
        end
    end
    assign int_show = r_seen || (int_dv != DIG_ZERO) ||
                      (r_cnt == CNT_W'(INT_DIGITS - 1));

    always_comb begin
        if (r_round && r_fnn_valid && (r_cnt == CNT_W'(r_fnn))) begin
            frac_dv = ram_rdata + DIG_ONE;
        end else if (r_round && (!r_fnn_valid || (r_cnt > CNT_W'(r_fnn)))) begin
            frac_dv = DIG_ZERO;
        end else begin
            frac_dv = ram_rdata;
        end
    end

    // operand select for the shared unit
    always_comb begin
        alu_op = ALU_SUB;
        alu_a  = '0;
        alu_b  = '0;
        if (r_state == ST_DIV) begin
            alu_a = UW'({r_acc[W-1:0], r_q[W-1]});
            alu_b = UW'(r_den);
        end else if (r_state == ST_FRAC) begin
            if (r_sub == SUB_MUL) begin
                alu_op = ALU_ADD;
                alu_a  = r_acc << 3;
                alu_b  = r_acc << 1;
            end else begin
                alu_a = r_acc;
                alu_b = UW'(r_den) << (SUB_LAST - r_sub);
            end
        end
    end

    dqf_alu #(.WIDTH(UW)) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    dqf_bcd #(.NUM_DIG(INT_DIGITS)) u_bcd (
        .i_clk (i_clk),
        .i_ctl (bcd_ctl),
        .o_top (bcd_top)
    );

    dqf_ram #(.WIDTH(SYM_W), .DEPTH(RAM_DEPTH)) u_frac_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_waddr = r_cnt[FRAC_AW-1:0];
    assign ram_wdata = dig_final;
    assign ram_raddr = (r_state == ST_EFRAC) ? cnt_inc[FRAC_AW-1:0] : r_cnt[FRAC_AW-1:0];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_out.ready;
        n_cnt       = r_cnt;
        n_sub       = r_sub;
        n_acc       = r_acc;
        n_q         = r_q;
        n_den       = r_den;
        n_places    = r_places;
        n_dig       = r_dig;
        n_round     = r_round;
        n_fnn_valid = r_fnn_valid;
        n_fnn       = r_fnn;
        n_inn       = r_inn;
        n_seen      = r_seen;
        n_sym       = r_sym;
        n_err       = r_err;
        n_last      = r_last;
        bcd_ctl     = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_acc       = '0;
                    n_q         = in_dividend;
                    n_den       = in_divisor;
                    n_places    = in_places;
                    n_cnt       = '0;
                    bcd_ctl.clr = 1'b1;
                    n_state     = (in_divisor == '0) ? ST_ERR : ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                n_acc = alu_carry ? alu_res : alu_a;
                n_q   = {r_q[W-2:0], alu_carry};
                if (r_cnt == CNT_W'(W - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_BCD;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            ST_BCD: begin
                bcd_ctl.dabble = 1'b1;
                bcd_ctl.bit_in = r_q[W-1];
                n_q            = r_q << 1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    n_cnt       = '0;
                    n_sub       = SUB_MUL;
                    n_fnn_valid = 1'b0;
                    n_state     = ST_FRAC;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            ST_FRAC: begin
                if (r_sub == SUB_MUL) begin
                    n_acc = alu_res;
                    n_sub = r_sub + 3'd1;
                end else begin
                    n_acc = alu_carry ? alu_res : r_acc;
                    n_dig = {r_dig[1:0], alu_carry};
                    if (r_sub == SUB_LAST) begin
                        n_sub = SUB_MUL;
                        if (r_cnt == r_places) begin
                            // extra digit decides the rounding
                            n_round = (dig_final >= DIG_HALF);
                            n_cnt   = '0;
                            n_inn   = '0;
                            n_state = ST_SCAN;
                        end else begin
                            ram_we = 1'b1;
                            if (dig_final != DIG_NINE) begin
                                n_fnn_valid = 1'b1;
                                n_fnn       = r_cnt[FRAC_AW-1:0];
                            end
                            n_cnt = cnt_inc;
                        end
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end
            end
            ST_SCAN: begin
                // find the last integer digit that is not a nine
                bcd_ctl.rot = 1'b1;
                if (bcd_top != DIG_NINE) begin
                    n_inn = r_cnt[IDX_W-1:0];
                end
                if (r_cnt == CNT_W'(INT_DIGITS - 1)) begin
                    n_cnt   = '0;
                    n_seen  = 1'b0;
                    n_state = ST_EINT;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            ST_EINT: begin
                if (!int_show || out_free) begin
                    bcd_ctl.rot = 1'b1;
                    if (int_show) begin
                        n_out_valid = 1'b1;
                        n_sym       = int_dv;
                        n_err       = 1'b0;
                        n_last      = (r_cnt == CNT_W'(INT_DIGITS - 1)) && (r_places == '0);
                        n_seen      = 1'b1;
                    end
                    if (r_cnt == CNT_W'(INT_DIGITS - 1)) begin
                        n_cnt   = '0;
                        n_state = (r_places != '0) ? ST_EPT : ST_IDLE;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            ST_EPT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_sym       = SYM_POINT;
                    n_err       = 1'b0;
                    n_last      = 1'b0;
                    ram_re      = 1'b1;
                    n_state     = ST_EFRAC;
                end
            end
            ST_EFRAC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_sym       = frac_dv;
                    n_err       = 1'b0;
                    n_last      = (cnt_inc == r_places);
                    if (cnt_inc == r_places) begin
                        n_state = ST_IDLE;
                    end else begin
                        ram_re = 1'b1;
                        n_cnt  = cnt_inc;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_sym       = DIG_ZERO;
                    n_err       = 1'b1;
                    n_last      = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_sub       <= n_sub;
        r_acc       <= n_acc;
        r_q         <= n_q;
        r_den       <= n_den;
        r_places    <= n_places;
        r_dig       <= n_dig;
        r_round     <= n_round;
        r_fnn_valid <= n_fnn_valid;
        r_fnn       <= n_fnn;
        r_inn       <= n_inn;
        r_seen      <= n_seen;
        r_sym       <= n_sym;
        r_err       <= n_err;
        r_last      <= n_last;
    end

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.symbol    = r_sym;
    assign o_out.div_error = r_err;
    assign o_out.last      = r_last;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_BCD) |-> (r_acc < UW'(r_den)))
        else $error("remainder not below divisor");

    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (in_divisor == '0)) |=> (r_state == ST_ERR))
        else $error("zero divisor did not take the error path");

    a_frac_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_wdata <= DIG_NINE))
        else $error("fraction digit out of range");

    a_round_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EINT && int_hit && (r_cnt == CNT_W'(r_inn))) |->
        (bcd_top != DIG_NINE))
        else $error("rounding carry lands on a nine");

    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_sym <= SYM_POINT))
        else $error("symbol code out of range");

endmodule
